[hdl/assert_macros.svh]
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define CHK_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

[hdl/lss_pkg.sv]
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants of the latching solenoid sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package lss_pkg;
   localparam int CHANNELS_DEF = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [1:0] CSR_BOOST = 2'd0;
   localparam logic [1:0] CSR_BRIDGE = 2'd1;
   localparam logic [1:0] CSR_CLOSE = 2'd2;
   localparam logic [15:0] BOOST_RST = 16'd650;
   localparam logic [15:0] BRIDGE_RST = 16'd50;
   localparam logic [15:0] CLOSE_RST = 16'd1000;

   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_RUN = 2'd2;
   localparam logic [1:0] MODE_READ = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_BAD_CH = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_BUSY = 2'd3;

   localparam logic [2:0] SEL_START = 3'd0;
   localparam logic [2:0] SEL_RUN = 3'd1;
   localparam logic [2:0] SEL_REPEAT = 3'd2;
   localparam logic [2:0] SEL_FLOW = 3'd3;
   localparam logic [2:0] SEL_CYCLES = 3'd4;
   localparam logic [2:0] SEL_PHASE = 3'd5;
   localparam logic [2:0] SEL_FSTART = 3'd6;
   localparam logic [2:0] SEL_FEND = 3'd7;

   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_DELAY = 4'd1;
   localparam logic [3:0] PH_BOOST1 = 4'd2;
   localparam logic [3:0] PH_SET = 4'd3;
   localparam logic [3:0] PH_RUN = 4'd4;
   localparam logic [3:0] PH_FLOWSTOP = 4'd5;
   localparam logic [3:0] PH_BOOST_F = 4'd6;
   localparam logic [3:0] PH_TIMEUP = 4'd7;
   localparam logic [3:0] PH_BOOST_T = 4'd8;
   localparam logic [3:0] PH_RESET = 4'd9;
   localparam logic [3:0] PH_CLOSE = 4'd10;
   localparam logic [3:0] PH_REPEAT = 4'd11;

   localparam logic [31:0] MAX_SHORT_S = 32'd21600;
   localparam logic [31:0] MAX_DAY_S = 32'd86400;
   localparam logic [31:0] MAX_CYCLES = 32'd255;
   localparam logic [31:0] FLOW_OFF = 32'hFFFF_FFFF;
   localparam logic [31:0] MS_PER_S = 32'd1000;
   localparam logic [2:0] LINE_BOOST = 3'd1;

   typedef struct packed {
      logic [3:0]  phase;
      logic [31:0] start_ms;
      logic [14:0] start_s;
      logic [14:0] run_s;
      logic [16:0] repeat_s;
      logic [31:0] flow_lim;
      logic [7:0]  cycles;
      logic [31:0] flow_st;
      logic [31:0] flow_end;
   } chan_type;

   localparam chan_type CHAN_RST = '{phase: PH_IDLE, start_ms: '0, start_s: '0,
      run_s: '0, repeat_s: '0, flow_lim: FLOW_OFF, cycles: '0, flow_st: '0,
      flow_end: '0};

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  channel;
      logic [2:0]  setting_select;
      logic [31:0] setting_value;
      logic [31:0] now_ms;
      logic [31:0] flow_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic        drive_enable;
      logic [2:0]  drive_address;
   } rsp_type;
endpackage
`default_nettype wire

[hdl/lss_if.sv]
// ----------------------------------------------------------------------------
// lss_req_if / lss_rsp_if
// Valid/ready channels of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
interface lss_req_if;
   logic valid;
   logic ready;
   lss_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lss_rsp_if;
   logic valid;
   logic ready;
   lss_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/latching_solenoid_sequencer.sv]
// Latching solenoid sequencer, top level.
// A write/read/run word is read from the store, evaluated and answered (a bad
// channel skips the store); a tick visits channels in turn until one acts or the last.
// Throughput: one word at a time; bound by the read-modify-write of the state memory.
// Reset: synchronous; a clearing pass over every channel entry follows, no word taken meanwhile.
// ----------------------------------------------------------------------------
// latching_solenoid_sequencer
// Store of per-channel state plus the sequencing controller.
// ----------------------------------------------------------------------------
`default_nettype none
module latching_solenoid_sequencer #(
   parameter int CHANNELS = lss_pkg::CHANNELS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_enable,
   input  wire logic [lss_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lss_pkg::CSR_DATA_W-1:0] csr_write_data,
   lss_req_if.sink req,
   lss_rsp_if.source rsp
);
   localparam int AW = $clog2(CHANNELS + 1);
   logic rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   lss_pkg::chan_type rd_data, wr_data;

   lss_store #(.CHANNELS(CHANNELS)) u_store (
      .clock, .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
   );

   lss_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .req, .rsp, .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
   );
endmodule
`default_nettype wire

[hdl/lss_store.sv]
// ----------------------------------------------------------------------------
// lss_store
// Per-channel state memory, one read and one write port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lss_store #(
   parameter int CHANNELS = lss_pkg::CHANNELS_DEF
) (
   input  wire logic clock,
   input  wire logic rd_en,
   input  wire logic [$clog2(CHANNELS+1)-1:0] rd_addr,
   output lss_pkg::chan_type rd_data,
   input  wire logic wr_en,
   input  wire logic [$clog2(CHANNELS+1)-1:0] wr_addr,
   input  lss_pkg::chan_type wr_data
);
   lss_pkg::chan_type mem [CHANNELS];
   lss_pkg::chan_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[hdl/lss_ctrl.sv]
// ----------------------------------------------------------------------------
// lss_ctrl
// Sequencer: clears the store after reset, then per word reads channel
// entries, evaluates one at a time and writes back any updated entry.
// ----------------------------------------------------------------------------
`default_nettype none
module lss_ctrl #(
   parameter int CHANNELS = lss_pkg::CHANNELS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_enable,
   input  wire logic [lss_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lss_pkg::CSR_DATA_W-1:0] csr_write_data,
   lss_req_if.sink req,
   lss_rsp_if.source rsp,
   output logic rd_en,
   output logic [$clog2(CHANNELS+1)-1:0] rd_addr,
   input  lss_pkg::chan_type rd_data,
   output logic wr_en,
   output logic [$clog2(CHANNELS+1)-1:0] wr_addr,
   output lss_pkg::chan_type wr_data
);
   localparam int AW = $clog2(CHANNELS + 1);
   localparam logic [AW-1:0] LAST = AW'(CHANNELS - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_OUT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   lss_pkg::req_type req_ff, req_in;
   lss_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] boost_ff, boost_in, bridge_ff, bridge_in, close_ff, close_in;
   logic [1:0] bown_ff, bown_in, mown_ff, mown_in;
   logic don_ff, don_in;
   logic [2:0] dline_ff, dline_in;

   lss_pkg::chan_type ch;
   logic [1:0] id;
   logic [31:0] el, fdiff, start_ms32, run_ms32, rep_ms32, vmax, rd;
   logic [7:0] cyc_dec;
   logic done;
   logic [1:0] st;

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   always_comb begin
      id = 2'(idx_ff + AW'(1));
      el = req_ff.now_ms - rd_data.start_ms;
      fdiff = req_ff.flow_count - rd_data.flow_st;
      start_ms32 = 32'(rd_data.start_s) * lss_pkg::MS_PER_S;
      run_ms32 = 32'(rd_data.run_s) * lss_pkg::MS_PER_S;
      rep_ms32 = 32'(rd_data.repeat_s) * lss_pkg::MS_PER_S;
      cyc_dec = (rd_data.cycles != 8'd0) ? rd_data.cycles - 8'd1 : 8'd0;
      unique case (req_ff.setting_select)
         lss_pkg::SEL_START, lss_pkg::SEL_RUN: vmax = lss_pkg::MAX_SHORT_S;
         lss_pkg::SEL_REPEAT: vmax = lss_pkg::MAX_DAY_S;
         lss_pkg::SEL_FLOW: vmax = lss_pkg::FLOW_OFF;
         default: vmax = '0;
      endcase
      if (req_ff.mode == lss_pkg::MODE_RUN) vmax = lss_pkg::MAX_CYCLES;
      case (req_ff.setting_select)
         lss_pkg::SEL_START: rd = 32'(rd_data.start_s);
         lss_pkg::SEL_RUN: rd = 32'(rd_data.run_s);
         lss_pkg::SEL_REPEAT: rd = 32'(rd_data.repeat_s);
         lss_pkg::SEL_FLOW: rd = rd_data.flow_lim;
         lss_pkg::SEL_CYCLES: rd = 32'(rd_data.cycles);
         lss_pkg::SEL_PHASE: rd = 32'(rd_data.phase);
         lss_pkg::SEL_FSTART: rd = rd_data.flow_st;
         default: rd = rd_data.flow_end;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      boost_in = boost_ff;
      bridge_in = bridge_ff;
      close_in = close_ff;
      bown_in = bown_ff;
      mown_in = mown_ff;
      don_in = don_ff;
      dline_in = dline_ff;
      rd_en = 1'b0;
      rd_addr = idx_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = lss_pkg::CHAN_RST;
      ch = rd_data;
      done = 1'b0;
      st = lss_pkg::ST_OK;
      if (csr_write_enable) begin
         case (csr_index)
            lss_pkg::CSR_BOOST: boost_in = csr_write_data;
            lss_pkg::CSR_BRIDGE: bridge_in = csr_write_data;
            lss_pkg::CSR_CLOSE: close_in = csr_write_data;
            default: ;
         endcase
      end
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == LAST) begin
               idx_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid && req.ready) begin
               req_in = req.data;
               rsp_in.status = lss_pkg::ST_OK;
               rsp_in.read_value = '0;
               if (req.data.mode == lss_pkg::MODE_TICK) begin
                  idx_in = '0;
                  state_in = S_READ;
               end else if (req.data.channel == 3'd0 ||
                            32'(req.data.channel) > 32'(CHANNELS)) begin
                  rsp_in.status = lss_pkg::ST_BAD_CH;
                  state_in = S_OUT;
               end else begin
                  idx_in = AW'(req.data.channel - 3'd1);
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            rd_en = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (req_ff.mode == lss_pkg::MODE_TICK) begin
               if (ch.phase == lss_pkg::PH_DELAY && bown_ff == 2'd0 && mown_ff == 2'd0
                   && el > start_ms32) begin
                  don_in = 1'b1; dline_in = lss_pkg::LINE_BOOST;
                  ch.phase = lss_pkg::PH_BOOST1; ch.start_ms = req_ff.now_ms;
                  bown_in = id; mown_in = id; ch.flow_st = req_ff.flow_count;
                  done = 1'b1;
               end
               if (!done && mown_ff == id) begin
                  if (ch.phase == lss_pkg::PH_BOOST1 && bown_ff == id
                      && el > 32'(boost_ff)) begin
                     don_in = 1'b1; dline_in = {id, 1'b0};
                     ch.start_ms = req_ff.now_ms; ch.phase = lss_pkg::PH_SET;
                     done = 1'b1;
                  end else if (ch.phase == lss_pkg::PH_SET && bown_ff == id
                               && el > 32'(bridge_ff)) begin
                     bown_in = 2'd0; don_in = 1'b0;
                     ch.start_ms = req_ff.now_ms; ch.phase = lss_pkg::PH_RUN;
                     done = 1'b1;
                  end else begin
                     if (ch.phase == lss_pkg::PH_RUN) begin
                        if (el > run_ms32) ch.phase = lss_pkg::PH_TIMEUP;
                        if (ch.flow_lim != lss_pkg::FLOW_OFF && fdiff >= ch.flow_lim) begin
                           ch.phase = lss_pkg::PH_FLOWSTOP;
                           done = 1'b1;
                        end
                     end
                     if (done) begin
                     end else if (ch.phase == lss_pkg::PH_FLOWSTOP && bown_ff == 2'd0) begin
                        don_in = 1'b1; dline_in = lss_pkg::LINE_BOOST;
                        ch.phase = lss_pkg::PH_BOOST_F; ch.start_ms = req_ff.now_ms;
                        bown_in = id; done = 1'b1;
                     end else if (ch.phase == lss_pkg::PH_BOOST_F && bown_ff == id
                                  && el > 32'(boost_ff)) begin
                        don_in = 1'b1; dline_in = {id, 1'b1};
                        ch.start_ms = req_ff.now_ms; ch.phase = lss_pkg::PH_RESET;
                        done = 1'b1;
                     end else if (ch.phase == lss_pkg::PH_TIMEUP && bown_ff == 2'd0) begin
                        don_in = 1'b1; dline_in = lss_pkg::LINE_BOOST;
                        ch.phase = lss_pkg::PH_BOOST_T; ch.start_ms = req_ff.now_ms;
                        bown_in = id; done = 1'b1;
                     end else if (ch.phase == lss_pkg::PH_BOOST_T && bown_ff == id
                                  && el > 32'(boost_ff)) begin
                        don_in = 1'b1; dline_in = {id, 1'b1};
                        ch.start_ms = req_ff.now_ms; ch.phase = lss_pkg::PH_RESET;
                        done = 1'b1;
                     end else if (ch.phase == lss_pkg::PH_RESET && bown_ff == id
                                  && el > 32'(bridge_ff)) begin
                        bown_in = 2'd0; don_in = 1'b0;
                        ch.start_ms = req_ff.now_ms; ch.phase = lss_pkg::PH_CLOSE;
                        done = 1'b1;
                     end else if (ch.phase == lss_pkg::PH_CLOSE && el > 32'(close_ff)) begin
                        mown_in = 2'd0; ch.flow_end = req_ff.flow_count;
                        ch.cycles = cyc_dec;
                        if (cyc_dec != 8'd0) begin
                           ch.start_ms = req_ff.now_ms; ch.phase = lss_pkg::PH_REPEAT;
                        end else begin
                           ch.start_ms = '0; ch.phase = lss_pkg::PH_IDLE;
                        end
                        done = 1'b1;
                     end
                  end
               end
               if (!done && ch.phase == lss_pkg::PH_REPEAT && el > rep_ms32) begin
                  ch.start_ms = req_ff.now_ms - start_ms32;
                  ch.phase = lss_pkg::PH_DELAY;
                  done = 1'b1;
               end
               wr_en = 1'b1;
               wr_data = ch;
               if (done || idx_ff == LAST) begin
                  state_in = S_OUT;
               end else begin
                  idx_in = idx_ff + AW'(1);
                  state_in = S_READ;
               end
            end else begin
               if (req_ff.mode == lss_pkg::MODE_READ) begin
                  rsp_in.read_value = rd;
               end else begin
                  if (req_ff.setting_value == 32'd0 || req_ff.setting_value > vmax
                      || (req_ff.mode == lss_pkg::MODE_WRITE
                          && req_ff.setting_select[2])) begin
                     st = lss_pkg::ST_RANGE;
                  end else if (rd_data.phase != lss_pkg::PH_IDLE) begin
                     st = lss_pkg::ST_BUSY;
                  end else begin
                     wr_en = 1'b1;
                     if (req_ff.mode == lss_pkg::MODE_RUN) begin
                        ch.phase = lss_pkg::PH_DELAY;
                        ch.cycles = req_ff.setting_value[7:0];
                        ch.start_ms = req_ff.now_ms;
                     end else begin
                        case (req_ff.setting_select)
                           lss_pkg::SEL_START: ch.start_s = req_ff.setting_value[14:0];
                           lss_pkg::SEL_RUN: ch.run_s = req_ff.setting_value[14:0];
                           lss_pkg::SEL_REPEAT: ch.repeat_s = req_ff.setting_value[16:0];
                           default: ch.flow_lim = req_ff.setting_value;
                        endcase
                     end
                     wr_data = ch;
                  end
                  rsp_in.status = st;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_in.drive_enable = don_in;
               rsp_in.drive_address = dline_in;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         boost_ff <= lss_pkg::BOOST_RST;
         bridge_ff <= lss_pkg::BRIDGE_RST;
         close_ff <= lss_pkg::CLOSE_RST;
         bown_ff <= 2'd0;
         mown_ff <= 2'd0;
         don_ff <= 1'b0;
         dline_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         boost_ff <= boost_in;
         bridge_ff <= bridge_in;
         close_ff <= close_in;
         bown_ff <= bown_in;
         mown_ff <= mown_in;
         don_ff <= don_in;
         dline_ff <= dline_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

[hdl/lss_checker.sv]
// ----------------------------------------------------------------------------
// lss_checker
// Port-level checks of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lss_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic [31:0] rsp_read_value
);
   logic rsp_is_err;
   assign rsp_is_err = (rsp_status != lss_pkg::ST_OK);

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `CHK_IMPL(a_err_zero, clock, reset, !rsp_valid || !rsp_is_err || rsp_read_value == '0, "error with data")
   `CHK_NEXT(a_one_out, clock, reset, req_valid && req_ready, !req_ready, "second word taken")
   `CHK_IMPL(a_no_take, clock, reset, !(rsp_valid && req_ready), "accept while result pending")
endmodule
bind latching_solenoid_sequencer lss_checker u_lss_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data.status),
   .rsp_read_value(rsp.data.read_value)
);
`default_nettype wire

[test/latching_solenoid_sequencer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latching_solenoid_sequencer_test
// Self-checking bench for the solenoid sequencer. A clocked driver sends
// request words from a queue. A clocked monitor checks each response word
// against a predictor of the per-channel sequencing state. The run goes
// through several boost/bridge/close settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module latching_solenoid_sequencer_test;
   import lss_pkg::*;

   localparam int NCH = 3;
   localparam int LIMIT = 600000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   lss_req_if req_ch ();
   lss_rsp_if rsp_ch ();

   latching_solenoid_sequencer dut (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req(req_ch), .rsp(rsp_ch)
   );

   // predicted state
   logic [15:0] boost_ms, bridge_ms, close_ms;
   logic [3:0]  phase_q [NCH];
   logic [31:0] t0_ms [NCH];
   logic [14:0] delay_s [NCH];
   logic [14:0] runtime_s [NCH];
   logic [16:0] again_s [NCH];
   logic [31:0] flow_lim [NCH];
   logic [7:0]  cycles_q [NCH];
   logic [31:0] flow_st [NCH];
   logic [31:0] flow_end [NCH];
   logic [1:0]  boost_own, meter_own;
   logic        dec_on;
   logic [2:0]  dec_line;

   req_type pending_q[$];
   rsp_type response_q[$];
   int errors;
   int cycles;
   int send_idle_pct;
   int stall_pct;
   logic [31:0] now_cnt;
   logic [31:0] flow_cnt;

   function automatic void drive_line(logic [2:0] line);
      dec_line = line;
      dec_on = 1'b1;
   endfunction

   function automatic void seq_tick(logic [31:0] now, logic [31:0] flow);
      logic [1:0] id;
      logic [31:0] el;
      for (int c = 0; c < NCH; c++) begin
         id = 2'(c + 1);
         el = now - t0_ms[c];
         if (phase_q[c] == PH_DELAY && boost_own == 0 && meter_own == 0 &&
               el > 32'(delay_s[c]) * MS_PER_S) begin
            drive_line(LINE_BOOST);
            phase_q[c] = PH_BOOST1;
            t0_ms[c] = now;
            boost_own = id;
            meter_own = id;
            flow_st[c] = flow;
            return;
         end
         if (meter_own == id) begin
            if (phase_q[c] == PH_BOOST1 && boost_own == id && el > 32'(boost_ms)) begin
               drive_line({id, 1'b0});
               t0_ms[c] = now;
               phase_q[c] = PH_SET;
               return;
            end
            if (phase_q[c] == PH_SET && boost_own == id && el > 32'(bridge_ms)) begin
               boost_own = 0;
               dec_on = 1'b0;
               t0_ms[c] = now;
               phase_q[c] = PH_RUN;
               return;
            end
            if (phase_q[c] == PH_RUN) begin
               if (el > 32'(runtime_s[c]) * MS_PER_S) phase_q[c] = PH_TIMEUP;
               if (flow_lim[c] != FLOW_OFF && (flow - flow_st[c]) >= flow_lim[c]) begin
                  phase_q[c] = PH_FLOWSTOP;
                  return;
               end
            end
            if (phase_q[c] == PH_FLOWSTOP && boost_own == 0) begin
               drive_line(LINE_BOOST);
               phase_q[c] = PH_BOOST_F;
               t0_ms[c] = now;
               boost_own = id;
               return;
            end
            if (phase_q[c] == PH_BOOST_F && boost_own == id && el > 32'(boost_ms)) begin
               drive_line({id, 1'b1});
               t0_ms[c] = now;
               phase_q[c] = PH_RESET;
               return;
            end
            if (phase_q[c] == PH_TIMEUP && boost_own == 0) begin
               drive_line(LINE_BOOST);
               phase_q[c] = PH_BOOST_T;
               t0_ms[c] = now;
               boost_own = id;
               return;
            end
            if (phase_q[c] == PH_BOOST_T && boost_own == id && el > 32'(boost_ms)) begin
               drive_line({id, 1'b1});
               t0_ms[c] = now;
               phase_q[c] = PH_RESET;
               return;
            end
            if (phase_q[c] == PH_RESET && boost_own == id && el > 32'(bridge_ms)) begin
               boost_own = 0;
               dec_on = 1'b0;
               t0_ms[c] = now;
               phase_q[c] = PH_CLOSE;
               return;
            end
            if (phase_q[c] == PH_CLOSE && el > 32'(close_ms)) begin
               meter_own = 0;
               flow_end[c] = flow;
               if (cycles_q[c] != 0) cycles_q[c] = cycles_q[c] - 1;
               if (cycles_q[c] != 0) begin
                  t0_ms[c] = now;
                  phase_q[c] = PH_REPEAT;
               end else begin
                  t0_ms[c] = '0;
                  phase_q[c] = PH_IDLE;
               end
               return;
            end
         end
         if (phase_q[c] == PH_REPEAT && el > 32'(again_s[c]) * MS_PER_S) begin
            t0_ms[c] = now - 32'(delay_s[c]) * MS_PER_S;
            phase_q[c] = PH_DELAY;
            return;
         end
      end
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type o;
      int c;
      logic [31:0] top;
      o = '0;
      if (r.mode == MODE_TICK) begin
         seq_tick(r.now_ms, r.flow_count);
      end else if (r.channel < 1 || r.channel > NCH) begin
         o.status = ST_BAD_CH;
      end else begin
         c = int'(r.channel) - 1;
         if (r.mode == MODE_READ) begin
            case (r.setting_select)
               SEL_START:  o.read_value = 32'(delay_s[c]);
               SEL_RUN:    o.read_value = 32'(runtime_s[c]);
               SEL_REPEAT: o.read_value = 32'(again_s[c]);
               SEL_FLOW:   o.read_value = flow_lim[c];
               SEL_CYCLES: o.read_value = 32'(cycles_q[c]);
               SEL_PHASE:  o.read_value = 32'(phase_q[c]);
               SEL_FSTART: o.read_value = flow_st[c];
               default:    o.read_value = flow_end[c];
            endcase
         end else begin
            if (r.mode == MODE_RUN) top = MAX_CYCLES;
            else if (r.setting_select == SEL_START || r.setting_select == SEL_RUN)
               top = MAX_SHORT_S;
            else if (r.setting_select == SEL_REPEAT) top = MAX_DAY_S;
            else if (r.setting_select == SEL_FLOW) top = FLOW_OFF;
            else top = '0;
            if (r.setting_value < 1 || r.setting_value > top) o.status = ST_RANGE;
            else if (phase_q[c] != PH_IDLE) o.status = ST_BUSY;
            else if (r.mode == MODE_RUN) begin
               phase_q[c] = PH_DELAY;
               cycles_q[c] = r.setting_value[7:0];
               t0_ms[c] = r.now_ms;
            end else if (r.setting_select == SEL_START) delay_s[c] = r.setting_value[14:0];
            else if (r.setting_select == SEL_RUN) runtime_s[c] = r.setting_value[14:0];
            else if (r.setting_select == SEL_REPEAT) again_s[c] = r.setting_value[16:0];
            else flow_lim[c] = r.setting_value;
         end
      end
      o.drive_enable = dec_on;
      o.drive_address = dec_line;
      return o;
   endfunction

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            response_q.push_back(predict_response(req_ch.data));
            void'(pending_q.pop_front());
         end
         if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pending_q[0];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type exp_w;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (response_q.size() == 0) begin
               $error("unexpected response word");
               errors++;
            end else begin
               exp_w = response_q.pop_front();
               if (rsp_ch.data.status !== exp_w.status) begin
                  $error("status: expected %0d actual %0d", exp_w.status, rsp_ch.data.status);
                  errors++;
               end
               if (rsp_ch.data.read_value !== exp_w.read_value) begin
                  $error("read_value: expected %0h actual %0h", exp_w.read_value,
                     rsp_ch.data.read_value);
                  errors++;
               end
               if (rsp_ch.data.drive_enable !== exp_w.drive_enable) begin
                  $error("drive_enable: expected %0d actual %0d", exp_w.drive_enable,
                     rsp_ch.data.drive_enable);
                  errors++;
               end
               if (rsp_ch.data.drive_address !== exp_w.drive_address) begin
                  $error("drive_address: expected %0d actual %0d", exp_w.drive_address,
                     rsp_ch.data.drive_address);
                  errors++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_word(logic [1:0] mode, logic [2:0] ch, logic [2:0] sel,
         logic [31:0] val);
      req_type r;
      r.mode = mode;
      r.channel = ch;
      r.setting_select = sel;
      r.setting_value = val;
      r.now_ms = now_cnt;
      r.flow_count = flow_cnt;
      pending_q.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_q.size() > 0 || response_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_timing(logic [15:0] b, logic [15:0] br, logic [15:0] cl);
      logic [15:0] v [3];
      v[0] = b; v[1] = br; v[2] = cl;
      wait_drained();
      boost_ms = b; bridge_ms = br; close_ms = cl;
      for (int i = 0; i < 3; i++) begin
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_index <= (i == 0) ? CSR_BOOST : (i == 1) ? CSR_BRIDGE : CSR_CLOSE;
         csr_write_data <= v[i];
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_words(int n);
      int p;
      logic [2:0] ch;
      logic [2:0] sel;
      logic [31:0] val;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(99);
         ch = ($urandom_range(9) < 9) ? 3'($urandom_range(1, NCH)) : 3'($urandom_range(7));
         sel = 3'($urandom_range(7));
         val = $urandom;
         if (p < 65) begin
            if ($urandom_range(49) == 0) now_cnt = $urandom;
            else if ($urandom_range(3) == 0) now_cnt += $urandom_range(1, 3000);
            else now_cnt += $urandom_range(1, 400);
            if ($urandom_range(29) == 0) flow_cnt = $urandom;
            else flow_cnt += $urandom_range(0, 40);
            push_word(MODE_TICK, ch, sel, val);
         end else if (p < 76) begin
            case ($urandom_range(9))
               0: val = 0;
               1: val = 255;
               2: val = 256;
               3: ;
               default: val = $urandom_range(1, 4);
            endcase
            push_word(MODE_RUN, ch, sel, val);
         end else if (p < 88) begin
            if ($urandom_range(4) == 0) begin
               case ($urandom_range(3))
                  0: val = 0;
                  1: val = MAX_SHORT_S + $urandom_range(0, 1);
                  2: val = MAX_DAY_S + $urandom_range(0, 1);
                  default: val = FLOW_OFF;
               endcase
            end else if (sel == SEL_FLOW) val = $urandom_range(1, 300);
            else val = $urandom_range(1, 3);
            push_word(MODE_WRITE, ch, sel, val);
         end else begin
            push_word(MODE_READ, ch, sel, val);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      errors = 0;
      cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      now_cnt = 32'hFFFF_F000;
      flow_cnt = 32'hFFFF_FF00;
      boost_ms = BOOST_RST; bridge_ms = BRIDGE_RST; close_ms = CLOSE_RST;
      for (int c = 0; c < NCH; c++) begin
         phase_q[c] = PH_IDLE; t0_ms[c] = '0; delay_s[c] = '0; runtime_s[c] = '0;
         again_s[c] = '0; flow_lim[c] = FLOW_OFF; cycles_q[c] = '0;
         flow_st[c] = '0; flow_end[c] = '0;
      end
      boost_own = 0; meter_own = 0; dec_on = 1'b0; dec_line = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: errors, range edges, reads, a run that hits busy
      push_word(MODE_READ, 3'd0, SEL_FLOW, '1);
      push_word(MODE_WRITE, 3'd7, SEL_START, 32'd1);
      push_word(MODE_WRITE, 3'd1, SEL_START, 32'd0);
      push_word(MODE_WRITE, 3'd1, SEL_START, MAX_SHORT_S + 1);
      push_word(MODE_WRITE, 3'd1, SEL_START, MAX_SHORT_S);
      push_word(MODE_WRITE, 3'd1, SEL_RUN, MAX_SHORT_S);
      push_word(MODE_WRITE, 3'd1, SEL_REPEAT, MAX_DAY_S + 1);
      push_word(MODE_WRITE, 3'd1, SEL_REPEAT, MAX_DAY_S);
      push_word(MODE_WRITE, 3'd2, SEL_FLOW, FLOW_OFF);
      push_word(MODE_WRITE, 3'd2, SEL_CYCLES, 32'd1);
      push_word(MODE_WRITE, 3'd2, SEL_FEND, 32'd1);
      push_word(MODE_RUN, 3'd3, SEL_START, 32'd0);
      push_word(MODE_RUN, 3'd3, SEL_START, 32'd256);
      push_word(MODE_WRITE, 3'd3, SEL_FLOW, 32'd5);
      push_word(MODE_RUN, 3'd3, SEL_START, 32'd255);
      push_word(MODE_WRITE, 3'd3, SEL_START, 32'd1);
      push_word(MODE_RUN, 3'd3, SEL_START, 32'd2);
      for (int s = 0; s < 8; s++) push_word(MODE_READ, 3'd3, 3'(s), '0);
      wait_drained();

      random_words(375);
      set_timing(16'd0, 16'd0, 16'd0);
      send_idle_pct = 58;
      random_words(375);
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_idle_pct = 0;
      stall_pct = 58;
      random_words(375);
      set_timing(16'd7, 16'd3, 16'd20);
      send_idle_pct = 30;
      stall_pct = 30;
      random_words(375);

      wait_drained();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
